FILE: rtl/lrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

    // Data widths
    localparam int WORD_W = 32;                   // seed, bounds, result
    localparam int DVD_W  = 24;                   // draw bits taken from the seed
    localparam int DRAW_SHIFT = 8;                // seed bits 31:8 form the draw
    localparam int CNT_W  = $clog2(DVD_W + 1);    // remaining-iteration counter
    localparam int ACT_W  = 2;

    // Generator constants
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd2531011;

    // Action codes carried in tuser
    localparam logic [ACT_W-1:0] ACT_SIGNED   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UNSIGNED = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LCG,
        S_DIV,
        S_EMIT
    } t_state;

    // Per-cycle control broadcast to every divider cell
    typedef struct packed {
        logic load;   // clear partial remainder, latch divisor slice
        logic step;   // one shift/subtract iteration
        logic take;   // trial subtraction did not borrow: keep the difference
    } t_cell_ctrl;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, remainder is valid
    } t_div_stat;

endpackage

`default_nettype wire

FILE: rtl/lrr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slice of the restoring remainder datapath. Holds CELL_W bits of the
// partial remainder and of the divisor. The top remainder bit moves to the
// upper neighbor each step; the borrow ripples upward within the cycle.
module lrr_cell
    import lrr_pkg::*;
#(
    parameter int CELL_W = 8
) (
    input  wire              i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  wire [CELL_W-1:0] i_div_slice,
    input  wire              i_shift_in,
    input  wire              i_borrow_in,
    output logic             o_shift_out,
    output logic             o_borrow_out,
    output logic [CELL_W-1:0] o_rem
);

    logic [CELL_W-1:0] r_rem;
    logic [CELL_W-1:0] r_div;
    logic [CELL_W-1:0] w_shifted;
    logic [CELL_W:0]   w_sub;

    // Shift in the neighbor's bit, then trial subtract this slice
    always_comb begin
        w_shifted = {r_rem[CELL_W-2:0], i_shift_in};
        w_sub     = {1'b0, w_shifted} - {1'b0, r_div} - {{CELL_W{1'b0}}, i_borrow_in};
    end

    assign o_borrow_out = w_sub[CELL_W];
    assign o_shift_out  = r_rem[CELL_W-1];
    assign o_rem        = r_rem;

    // Slice registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= '0;
            r_div <= i_div_slice;
        end else if (i_ctrl.step) begin
            r_rem <= i_ctrl.take ? w_sub[CELL_W-1:0] : w_shifted;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lrr_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Remainder unit: a row of lrr_cell slices, one dividend bit per cycle.
module lrr_divider
    import lrr_pkg::*;
#(
    parameter int CELL_W = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [DVD_W-1:0]  i_dividend,
    input  wire [WORD_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [WORD_W-1:0] o_rem
);

    localparam int NCELL = WORD_W / CELL_W;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [NCELL:0]    w_borrow;
    logic [NCELL-1:0]  w_shin;
    t_cell_ctrl        w_ctrl;

    // Control shared by all cells; take comes off the top of the borrow chain
    always_comb begin
        w_ctrl.load = i_start;
        w_ctrl.step = r_busy;
        w_ctrl.take = ~w_borrow[NCELL];
    end

    assign w_borrow[0] = 1'b0;
    assign w_shin[0]   = r_dvd[DVD_W-1];

    // Cell row, lowest slice first
    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        if (gi < NCELL - 1) begin : g_mid
            lrr_cell #(.CELL_W(CELL_W)) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_div_slice  (i_divisor[gi*CELL_W +: CELL_W]),
                .i_shift_in   (w_shin[gi]),
                .i_borrow_in  (w_borrow[gi]),
                .o_shift_out  (w_shin[gi+1]),
                .o_borrow_out (w_borrow[gi+1]),
                .o_rem        (o_rem[gi*CELL_W +: CELL_W])
            );
        end else begin : g_top
            // remainder stays below 2^24, so the top bit shifted out is always 0
            lrr_cell #(.CELL_W(CELL_W)) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_div_slice  (i_divisor[gi*CELL_W +: CELL_W]),
                .i_shift_in   (w_shin[gi]),
                .i_borrow_in  (w_borrow[gi]),
                .o_shift_out  (),
                .o_borrow_out (w_borrow[gi+1]),
                .o_rem        (o_rem[gi*CELL_W +: CELL_W])
            );
        end
    end

    // Dividend shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
        end
    end

    // Iteration counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    // Busy exactly while iterations remain
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_cnt != '0))
        else $error("divider busy flag out of step with counter");

    // Done pulse only follows the last iteration
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

    // A new run starts only once the previous one has finished
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: rtl/lcg_ranged_random_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake                      Payload
// s_axis     in   s_axis_tvalid / s_axis_tready  tdata: range_low, range_high, seed_value
//                                                tuser: action
// m_axis     out  m_axis_tvalid / m_axis_tready  tdata: draw_value
//
// A non-empty draw fills the output register after a generator step (S_LCG),
// 24 remainder steps (one dividend bit per cycle through the cell row), the
// divider done flag (S_DIV) and the add of the lower bound (S_EMIT).
// An empty-range draw goes straight to S_EMIT. The input reopens only once the
// result is in the output register; a load or unused action is taken at once.
// A waiting result stalls only the next result; i_rst_n (sync, low) zeroes the seed.
module lcg_ranged_random_top
    import lrr_pkg::*;
#(
    parameter int CELL_W = 8   // slice width of the divider cells, divides 32, 2..32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [95:0]  s_axis_tdata,   // [31:0] range_low, [63:32] range_high, [95:64] seed_value
    input  wire [1:0]   s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] draw_value
);

    t_state             r_state, n_state;
    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_low;
    logic [WORD_W-1:0]  r_diff;
    logic               r_empty;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_data;

    logic [ACT_W-1:0]   w_action;
    logic [WORD_W-1:0]  w_in_low;
    logic [WORD_W-1:0]  w_in_high;
    logic [WORD_W-1:0]  w_in_seed;
    logic [WORD_W-1:0]  w_in_diff;
    logic               w_in_empty;
    logic               w_accept;
    logic               w_is_draw;
    logic               w_is_load;
    logic [WORD_W-1:0]  w_lcg_next;
    logic               w_div_start;
    logic               w_out_load;
    logic [WORD_W-1:0]  w_rem;
    t_div_stat          w_div_stat;

    // Input unpacking and range check
    always_comb begin
        w_action   = s_axis_tuser;
        w_in_low   = s_axis_tdata[31:0];
        w_in_high  = s_axis_tdata[63:32];
        w_in_seed  = s_axis_tdata[95:64];
        w_in_diff  = w_in_high - w_in_low;
        w_in_empty = (w_in_diff == '0) ||
                     ((w_action == ACT_SIGNED) && w_in_diff[WORD_W-1]);
        w_is_draw  = (w_action == ACT_SIGNED) || (w_action == ACT_UNSIGNED);
        w_is_load  = (w_action == ACT_LOAD);
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Generator step, modulo 2^32
    assign w_lcg_next = (r_seed * LCG_MUL) + LCG_ADD;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (w_action) inside
                        ACT_SIGNED, ACT_UNSIGNED: n_state = w_in_empty ? S_EMIT : S_LCG;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_LCG:  n_state = S_DIV;
            S_DIV:  if (w_div_stat.done) n_state = S_EMIT;
            S_EMIT: if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_LCG:  w_div_start   = 1'b1;
            S_DIV:  ;
            S_EMIT: w_out_load    = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // Remainder unit
    lrr_divider #(.CELL_W(CELL_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_lcg_next[DRAW_SHIFT +: DVD_W]),
        .i_divisor  (r_diff),
        .o_stat     (w_div_stat),
        .o_rem      (w_rem)
    );

    // Control and seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && w_is_load) begin
                r_seed <= w_in_seed;
            end else if (w_div_start) begin
                r_seed <= w_lcg_next;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Draw payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_draw) begin
            r_low   <= w_in_low;
            r_diff  <= w_in_diff;
            r_empty <= w_in_empty;
        end
        if (w_out_load) begin
            r_out_data <= r_low + (r_empty ? '0 : w_rem);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Seed moves only on a load or on a generator step
    a_seed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_accept && w_is_load) && (r_state != S_LCG) |=> $stable(r_seed))
        else $error("seed changed outside load or generator step");

    // Divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider done outside wait state");

    // A load never produces a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_load) |=> (r_state == S_IDLE) && !$rose(m_axis_tvalid))
        else $error("load produced a result");

endmodule

`default_nettype wire
